// ===== hw/rtl/assert_macros.svh =====
// assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property that holds on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// implication whose consequent is checked in the cycle after its antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

// ===== hw/rtl/rfx_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfx_pkg
// shared constants for the range flip xor tree
// ----------------------------------------------------------------------------
package rfx_pkg;
  localparam int KIND_BITS = 2;
  localparam int POS_BITS  = 10;
  localparam int LEN_BITS  = 11;
  localparam logic [KIND_BITS-1:0] KIND_LOAD  = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_FLIP  = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_QUERY = 2'd2;
  localparam logic [0:0] REG_LENGTH = 1'b0;
endpackage

// ===== hw/rtl/rfx_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfx_in_if / rfx_out_if
// valid/ready channels for input items and query results
// ----------------------------------------------------------------------------
interface rfx_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [9:0]  position;
  logic [31:0] value;
  logic        tag;
  logic [9:0]  lo;
  logic [9:0]  hi;
  logic        group;
  modport source (output valid, kind, position, value, tag, lo, hi, group, input ready);
  modport sink (input valid, kind, position, value, tag, lo, hi, group, output ready);
endinterface

interface rfx_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] xor_result;
  modport source (output valid, xor_result, input ready);
  modport sink (input valid, xor_result, output ready);
endinterface

// ===== hw/rtl/range_flip_xor_segment_tree_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_flip_xor_segment_tree_top
// lazy segment tree with tag flips and per-tag xor queries, node memory walked
// by a sequencer with an explicit stack
// ----------------------------------------------------------------------------
// a load walks the path from the root down to its leaf; a flip or a query
// descends through partly covered nodes and stops at covered or disjoint ones
// a node whose flip mark is clear skips its push
// throughput: one transaction at a time, ready only while idle
// reset: synchronous active-low; a clearing pass over all node memory entries follows
`include "assert_macros.svh"

module range_flip_xor_segment_tree_top #(
  parameter int MAX_LENGTH = 1024,
  parameter int VALUE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  rfx_in_if.sink      in_ch,
  rfx_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  localparam int LB = $clog2(MAX_LENGTH);
  localparam int NB = LB + 1;
  localparam int NODES = 2 ** NB;
  localparam int DB = $clog2(LB + 2);
  localparam int PB = rfx_pkg::POS_BITS;
  localparam int CB = (LB > PB ? LB : PB) + 1;
  localparam logic [CB-1:0] LAST = CB'(MAX_LENGTH - 1);

  typedef struct packed {
    logic [VALUE_BITS-1:0] z;
    logic [VALUE_BITS-1:0] o;
    logic                  f;
  } node_t;

  // one stack frame per tree level
  typedef struct packed {
    logic [NB-1:0] node;
    logic [CB-1:0] l;
    logic [CB-1:0] r;
    logic [1:0]    phase; // 0 enter, 1 left done, 2 right done
  } frame_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_ENTER, S_RDP, S_RDL, S_PUSHL, S_RDR, S_PUSHR, S_CLRF,
    S_CALL, S_RDC0, S_RDC1, S_PULL, S_RET, S_OUT
  } state_t;

  // node memory
  node_t         mem [NODES];
  logic [NB-1:0] maddr;
  logic          mwe;
  node_t         mwd;
  node_t         mrd_r;
  always_ff @(posedge clk) begin
    if (mwe) mem[maddr] <= mwd;
    mrd_r <= mem[maddr];
  end

  state_t          state_r, state_nxt;
  frame_t          stk_r [LB+1];
  logic [DB-1:0]   sp_r;
  logic [NB:0]     clr_r;
  logic [LB:0]     len_r;
  logic [1:0]      kind_r;
  logic [CB-1:0]   a_r, b_r, pos_r;
  logic [VALUE_BITS-1:0] val_r, acc_r, res_r;
  logic            tag_r, grp_r, ovalid_r;
  node_t           par_r, c0_r;
  logic [LB:0]     wlen;
  logic [CB-1:0]   hi_sat, cur_m;
  frame_t          cur;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = 32'(len_r);
  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = ovalid_r;
  assign out_ch.xor_result = 32'(res_r);

  // written length clamped into 1..MAX_LENGTH
  always_comb begin
    if (cfg_pwdata[10:0] == 11'd0) wlen = (LB+1)'(1);
    else if ({21'd0, cfg_pwdata[10:0]} > 32'(MAX_LENGTH)) wlen = (LB+1)'(MAX_LENGTH);
    else wlen = (LB+1)'(cfg_pwdata[10:0]);
  end

  always_comb begin
    if (CB'(in_ch.hi) > CB'(len_r) - CB'(1)) hi_sat = CB'(len_r) - CB'(1);
    else hi_sat = CB'(in_ch.hi);
  end

  assign cur = stk_r[sp_r[DB-1:0]];
  assign cur_m = cur.l + ((cur.r - cur.l) >> 1);

  // node memory address and write data
  always_comb begin
    maddr = cur.node;
    mwe = 1'b0;
    mwd = par_r;
    unique case (state_r)
      S_CLEAR: begin
        maddr = clr_r[NB-1:0];
        mwe = 1'b1;
        mwd = '0;
      end
      S_RDL: maddr = {cur.node[NB-2:0], 1'b0};
      S_PUSHL: begin
        maddr = {cur.node[NB-2:0], 1'b0};
        mwe = par_r.f;
        mwd = '{z: mrd_r.o, o: mrd_r.z, f: ~mrd_r.f};
      end
      S_RDR: maddr = {cur.node[NB-2:0], 1'b1};
      S_PUSHR: begin
        maddr = {cur.node[NB-2:0], 1'b1};
        mwe = par_r.f;
        mwd = '{z: mrd_r.o, o: mrd_r.z, f: ~mrd_r.f};
      end
      S_CLRF: begin
        mwe = par_r.f;
        mwd = '{z: par_r.z, o: par_r.o, f: 1'b0};
      end
      S_RDC0: maddr = {cur.node[NB-2:0], 1'b0};
      S_RDC1: maddr = {cur.node[NB-2:0], 1'b1};
      S_PULL: begin
        mwe = 1'b1;
        mwd = '{z: c0_r.z ^ mrd_r.z, o: c0_r.o ^ mrd_r.o, f: 1'b0};
      end
      S_RET: begin
        mwe = (kind_r == rfx_pkg::KIND_FLIP) && cur.l >= a_r && cur.r <= b_r
              || (kind_r == rfx_pkg::KIND_LOAD) && cur.l == cur.r;
        if (kind_r == rfx_pkg::KIND_LOAD)
          mwd = '{z: tag_r ? '0 : val_r, o: tag_r ? val_r : '0, f: 1'b0};
        else
          mwd = '{z: mrd_r.o, o: mrd_r.z, f: ~mrd_r.f};
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_r == (NB+1)'(NODES - 1)) state_nxt = S_IDLE;
      default: ;
    endcase
  end

  // sequencer: state, stack and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      sp_r <= '0;
      len_r <= (LB+1)'(MAX_LENGTH < 1024 ? MAX_LENGTH : 1024);
      ovalid_r <= 1'b0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == {rfx_pkg::REG_LENGTH, 1'b0})
        len_r <= wlen;
      if (ovalid_r && out_ch.ready) ovalid_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          state_r <= state_nxt;
        end
        S_IDLE: if (in_ch.valid) begin
          kind_r <= in_ch.kind;
          a_r <= CB'(in_ch.lo);
          b_r <= hi_sat;
          pos_r <= CB'(in_ch.position);
          val_r <= VALUE_BITS'(in_ch.value);
          tag_r <= in_ch.tag;
          grp_r <= in_ch.group;
          acc_r <= '0;
          sp_r <= '0;
          stk_r[0] <= '{node: NB'(1), l: '0, r: LAST, phase: 2'd0};
          if (in_ch.kind == rfx_pkg::KIND_LOAD && CB'(in_ch.position) < CB'(len_r)
              || in_ch.kind == rfx_pkg::KIND_FLIP && CB'(in_ch.lo) <= hi_sat
              || in_ch.kind == rfx_pkg::KIND_QUERY && CB'(in_ch.lo) <= hi_sat)
            state_r <= S_ENTER;
          else if (in_ch.kind == rfx_pkg::KIND_QUERY)
            state_r <= S_OUT;
        end
        S_ENTER: begin
          // decide for the current frame: outside, covered or descend
          if (kind_r != rfx_pkg::KIND_LOAD && (cur.l > b_r || cur.r < a_r))
            state_r <= S_RET;
          else if (kind_r != rfx_pkg::KIND_LOAD && cur.l >= a_r && cur.r <= b_r
                   || kind_r == rfx_pkg::KIND_LOAD && cur.l == cur.r)
            state_r <= S_RET;
          else state_r <= S_RDP;
        end
        S_RDP: state_r <= S_RDL; // mrd_r gets parent next
        S_RDL: begin
          // no pending mark on the parent, nothing to push down
          if (mrd_r.f) state_r <= S_PUSHL;
          else state_r <= S_CALL;
        end
        S_PUSHL: state_r <= S_RDR;
        S_RDR: state_r <= S_PUSHR;
        S_PUSHR: state_r <= S_CLRF;
        S_CLRF: state_r <= S_CALL;
        S_CALL: begin
          if (cur.phase == 2'd0) begin
            if (kind_r == rfx_pkg::KIND_LOAD && pos_r > cur_m)
              stk_r[sp_r] <= '{node: cur.node, l: cur.l, r: cur.r, phase: 2'd2};
            else stk_r[sp_r] <= '{node: cur.node, l: cur.l, r: cur.r, phase: 2'd1};
            sp_r <= sp_r + 1'b1;
            if (kind_r == rfx_pkg::KIND_LOAD && pos_r > cur_m)
              stk_r[sp_r + 1'b1] <= '{node: {cur.node[NB-2:0], 1'b1},
                                      l: cur_m + 1'b1, r: cur.r, phase: 2'd0};
            else
              stk_r[sp_r + 1'b1] <= '{node: {cur.node[NB-2:0], 1'b0},
                                      l: cur.l, r: cur_m, phase: 2'd0};
            state_r <= S_ENTER;
          end else if (cur.phase == 2'd1 && kind_r != rfx_pkg::KIND_LOAD) begin
            stk_r[sp_r].phase <= 2'd2;
            sp_r <= sp_r + 1'b1;
            stk_r[sp_r + 1'b1] <= '{node: {cur.node[NB-2:0], 1'b1},
                                    l: cur_m + 1'b1, r: cur.r, phase: 2'd0};
            state_r <= S_ENTER;
          end else if (kind_r == rfx_pkg::KIND_QUERY) begin
            state_r <= S_RET;
          end else state_r <= S_RDC0;
        end
        S_RDC0: state_r <= S_RDC1;
        S_RDC1: state_r <= S_PULL;
        S_PULL: state_r <= S_RET;
        S_RET: begin
          // load leaf and covered flip writes done above; query gathers covered nodes
          if (kind_r == rfx_pkg::KIND_QUERY && cur.phase == 2'd0
              && cur.l >= a_r && cur.r <= b_r && !(cur.l > b_r || cur.r < a_r))
            acc_r <= acc_r ^ (grp_r ? mrd_r.o : mrd_r.z);
          if (sp_r == '0) begin
            if (kind_r == rfx_pkg::KIND_QUERY) state_r <= S_OUT;
            else state_r <= S_IDLE;
          end else begin
            sp_r <= sp_r - 1'b1;
            state_r <= S_CALL;
          end
        end
        S_OUT: if (!ovalid_r) begin
          res_r <= acc_r;
          ovalid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
      // capture memory data needed later
      if (state_r == S_RDL) par_r <= mrd_r;
      if (state_r == S_RDC1) c0_r <= mrd_r;
    end
  end

  `ASSERT_CLK(a_sp_range, clk, rst_n, sp_r <= DB'(LB), "stack overflow")
  `ASSERT_NEXT(a_out_hold, clk, rst_n, ovalid_r && !out_ch.ready, ovalid_r, "result dropped")
  `ASSERT_CLK(a_ready_busy, clk, rst_n, !(in_ch.ready && ovalid_r && state_r == S_OUT), "bad state")
endmodule

// ===== tb/sv/range_flip_xor_segment_tree_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_flip_xor_segment_tree_top_tb
// drives load, flip, query and unused-kind transactions through the range flip xor tree,
// predicts every query from a flat array of values and tags, and compares
// each result in order; the length register is rewritten between phases
// ----------------------------------------------------------------------------
module range_flip_xor_segment_tree_top_tb;

  typedef struct packed {
    logic [rfx_pkg::KIND_BITS-1:0] kind;
    logic [rfx_pkg::POS_BITS-1:0]  position;
    logic [31:0]                   value;
    logic                          tag;
    logic [rfx_pkg::POS_BITS-1:0]  lo;
    logic [rfx_pkg::POS_BITS-1:0]  hi;
    logic                          group;
  } tree_op_t;

  localparam int MAX_LEN = 1024;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [1:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  rfx_in_if  in_ch();
  rfx_out_if out_ch();

  range_flip_xor_segment_tree_top u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #5 clk = ~clk;

  // shadow of the array: plain values and tags, flips applied eagerly
  logic [31:0] shadow_value [MAX_LEN];
  logic        shadow_tag [MAX_LEN];
  int unsigned cur_length;

  tree_op_t    pending_ops[$];
  logic [31:0] expected_xor[$];
  int          error_count = 0;
  int          items_sent = 0;
  bit          hold_sender = 1'b0;

  // append one transaction to the driver queue
  task automatic enqueue_op(input tree_op_t op);
    pending_ops = {pending_ops, op};
  endtask

  // apply one accepted transaction to the shadow, queue a result for a query
  task automatic apply_op(input tree_op_t op);
    int unsigned top_pos;
    logic [31:0] acc;
    top_pos = (op.hi > cur_length - 1) ? cur_length - 1 : op.hi;
    acc = '0;
    case (op.kind)
      rfx_pkg::KIND_LOAD: begin
        if (op.position < cur_length) begin
          shadow_value[op.position] = op.value;
          shadow_tag[op.position]   = op.tag;
        end
      end
      rfx_pkg::KIND_FLIP: begin
        for (int i = op.lo; i <= int'(top_pos); i++) shadow_tag[i] = ~shadow_tag[i];
      end
      rfx_pkg::KIND_QUERY: begin
        for (int i = op.lo; i <= int'(top_pos); i++)
          if (shadow_tag[i] == op.group) acc ^= shadow_value[i];
        expected_xor = {expected_xor, acc};
      end
      default: ;
    endcase
  endtask

  function automatic tree_op_t make_op(logic [1:0] k, int p, logic [31:0] v, logic t,
                                       int l, int h, logic g);
    tree_op_t op;
    op.kind = k; op.position = p[9:0]; op.value = v; op.tag = t;
    op.lo = l[9:0]; op.hi = h[9:0]; op.group = g;
    return op;
  endfunction

  // random transaction, ranges biased toward the active length
  function automatic tree_op_t random_op();
    int unsigned r, lim, a, b;
    logic [1:0] k;
    r = $urandom_range(99);
    k = (r < 40) ? rfx_pkg::KIND_LOAD : (r < 65) ? rfx_pkg::KIND_FLIP :
        (r < 97) ? rfx_pkg::KIND_QUERY : KIND_UNUSED;
    lim = ($urandom_range(9) == 0) ? 1023 : cur_length - 1;
    a = $urandom_range(lim); b = $urandom_range(lim);
    if ($urandom_range(7) != 0 && a > b) begin
      r = a; a = b; b = r;
    end
    return make_op(k, $urandom_range(lim), $urandom, $urandom_range(1), a, b,
                   $urandom_range(1));
  endfunction

  // input driver
  int unsigned send_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_ch.ready) begin
      // hold the transaction
    end else begin
      if (in_ch.valid && in_ch.ready) send_gap = $urandom_range(3) == 0 ? 0 : $urandom_range(13);
      if (send_gap > 0 || hold_sender || pending_ops.size() == 0) begin
        if (send_gap > 0) send_gap--;
        in_ch.valid <= 1'b0;
      end else begin
        tree_op_t op;
        op = pending_ops.pop_front();
        in_ch.valid    <= 1'b1;
        in_ch.kind     <= op.kind;
        in_ch.position <= op.position;
        in_ch.value    <= op.value;
        in_ch.tag      <= op.tag;
        in_ch.lo       <= op.lo;
        in_ch.hi       <= op.hi;
        in_ch.group    <= op.group;
      end
    end
  end

  // acceptance on the input side updates the prediction
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      apply_op({in_ch.kind, in_ch.position, in_ch.value, in_ch.tag, in_ch.lo, in_ch.hi,
                in_ch.group});
      items_sent++;
    end
  end

  // result monitor with random backpressure
  int unsigned stall_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_xor.size() == 0) begin
          $error("unexpected transaction: xor_result actual %h", out_ch.xor_result);
          error_count++;
        end else begin
          logic [31:0] want;
          want = expected_xor.pop_front();
          if (out_ch.xor_result !== want) begin
            $error("xor_result expected %h actual %h", want, out_ch.xor_result);
            error_count++;
          end
        end
        stall_left = $urandom_range(3) == 0 ? 0 : $urandom_range(13);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic write_length(input logic [31:0] v);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= {rfx_pkg::REG_LENGTH, 1'b0} << 1; cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    v = v & 32'h7FF;
    cur_length = (v == 0) ? 1 : (v > MAX_LEN) ? MAX_LEN : v;
  endtask

  // wait until the block is idle with nothing queued or outstanding
  task automatic drain();
    while (pending_ops.size() != 0 || in_ch.valid || expected_xor.size() != 0
           || !in_ch.ready)
      @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic run_random(input int n);
    for (int i = 0; i < n; i++) enqueue_op(random_op());
  endtask

  // stimulus
  initial begin
    int lengths[6];
    lengths = '{1024, 1, 2, 37, 0, 2047};
    in_ch.valid = 1'b0; in_ch.kind = '0; in_ch.position = '0; in_ch.value = '0;
    in_ch.tag = 1'b0; in_ch.lo = '0; in_ch.hi = '0; in_ch.group = 1'b0;
    out_ch.ready = 1'b0;
    cur_length = MAX_LEN;
    for (int i = 0; i < MAX_LEN; i++) begin
      shadow_value[i] = '0; shadow_tag[i] = 1'b0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, every kind, empty ranges, ignored items
    enqueue_op(make_op(rfx_pkg::KIND_QUERY, 0, 0, 0, 0, 1023, 0));
    enqueue_op(make_op(rfx_pkg::KIND_LOAD, 0, 32'hFFFF_FFFF, 1, 0, 0, 0));
    enqueue_op(make_op(rfx_pkg::KIND_LOAD, 1023, 32'h8000_0001, 0, 0, 0, 0));
    enqueue_op(make_op(rfx_pkg::KIND_LOAD, 512, 32'h5A5A_A5A5, 1, 0, 0, 0));
    enqueue_op(make_op(rfx_pkg::KIND_QUERY, 0, 0, 0, 0, 1023, 1));
    enqueue_op(make_op(rfx_pkg::KIND_QUERY, 0, 0, 0, 0, 1023, 0));
    enqueue_op(make_op(rfx_pkg::KIND_FLIP, 0, 0, 0, 0, 1023, 0));
    enqueue_op(make_op(rfx_pkg::KIND_QUERY, 0, 0, 0, 0, 1023, 1));
    enqueue_op(make_op(rfx_pkg::KIND_FLIP, 0, 0, 0, 300, 600, 0));
    enqueue_op(make_op(rfx_pkg::KIND_QUERY, 0, 0, 0, 511, 1023, 0));
    enqueue_op(make_op(rfx_pkg::KIND_FLIP, 0, 0, 0, 700, 5, 0));
    enqueue_op(make_op(rfx_pkg::KIND_QUERY, 0, 0, 0, 900, 3, 1));
    enqueue_op(make_op(KIND_UNUSED, 5, 32'h1234, 1, 0, 1023, 1));
    enqueue_op(make_op(rfx_pkg::KIND_QUERY, 0, 0, 0, 1023, 1023, 0));
    enqueue_op(make_op(rfx_pkg::KIND_QUERY, 0, 0, 0, 512, 512, 1));
    drain();

    // short length, saturated range end and ignored loads
    write_length(32'd5);
    enqueue_op(make_op(rfx_pkg::KIND_LOAD, 900, 32'hDEAD_BEEF, 1, 0, 0, 0));
    enqueue_op(make_op(rfx_pkg::KIND_FLIP, 0, 0, 0, 2, 1023, 0));
    enqueue_op(make_op(rfx_pkg::KIND_QUERY, 0, 0, 0, 0, 1023, 1));
    enqueue_op(make_op(rfx_pkg::KIND_QUERY, 0, 0, 0, 7, 1023, 0));
    drain();
    write_length(32'd1024);
    enqueue_op(make_op(rfx_pkg::KIND_QUERY, 0, 0, 0, 0, 1023, 0));
    enqueue_op(make_op(rfx_pkg::KIND_QUERY, 0, 0, 0, 0, 1023, 1));
    drain();

    // random phases over several lengths
    foreach (lengths[i]) begin
      write_length(lengths[i]);
      run_random(240);
      if (i == 2) begin
        // let the pipeline empty fully before resuming
        while (pending_ops.size() > 120) @(posedge clk);
        hold_sender = 1'b1;
        while (in_ch.valid || expected_xor.size() != 0) @(posedge clk);
        hold_sender = 1'b0;
      end
      drain();
    end

    if (error_count == 0) $display("range_flip_xor_segment_tree_top_tb: done, clean");
    else $display("range_flip_xor_segment_tree_top_tb: done, errors");
    $finish;
  end

  // watchdog
  initial begin
    #40ms;
    $display("range_flip_xor_segment_tree_top_tb: done, errors");
    $finish;
  end
endmodule
